// ----- src/hre_pkg.sv -----
package hre_pkg;

  // Data bytes per record.
  localparam int RECORD_BYTES = 16;
  localparam int POS_W = $clog2(RECORD_BYTES + 1);

  localparam int ADDR_W = 16;
  localparam int LEN_W = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 17;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ORIGIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_LENGTH = 2'd1;

  // Highest end address plus one that an image may reach.
  localparam logic [LEN_W:0] ADDR_SPACE = 18'h10000;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_PAST_END = 2'd3
  } status_t;

  // Character positions within the text that one byte can produce.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_COLON     = 5'd0;
  localparam step_t STEP_COUNT_HI  = 5'd1;
  localparam step_t STEP_COUNT_LO  = 5'd2;
  localparam step_t STEP_ADDRH_HI  = 5'd3;
  localparam step_t STEP_ADDRH_LO  = 5'd4;
  localparam step_t STEP_ADDRL_HI  = 5'd5;
  localparam step_t STEP_ADDRL_LO  = 5'd6;
  localparam step_t STEP_TYPE_HI   = 5'd7;
  localparam step_t STEP_TYPE_LO   = 5'd8;
  localparam step_t STEP_DATA_HI   = 5'd9;
  localparam step_t STEP_DATA_LO   = 5'd10;
  localparam step_t STEP_CKS_HI    = 5'd11;
  localparam step_t STEP_CKS_LO    = 5'd12;
  localparam step_t STEP_NEWLINE   = 5'd13;
  localparam step_t STEP_END_FIRST = 5'd14;
  localparam step_t STEP_END_LAST  = 5'd25;

  localparam logic [6:0] CHAR_COLON = 7'h3A;
  localparam logic [6:0] CHAR_NEWLINE = 7'h0A;
  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_NONE = 7'h00;

  // One queued request for the character sequencer.
  typedef struct packed {
    status_t     status;
    logic        header;
    logic        checksum;
    logic        end_record;
    logic [7:0]  count;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [7:0]  cks;
  } cmd_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = CHAR_ZERO + {3'd0, nib};
    end else begin
      c = 7'h37 + {3'd0, nib};
    end
    return c;
  endfunction

  // The end-of-file record ":00000001FF" and its newline.
  function automatic logic [6:0] end_char(input logic [3:0] idx);
    logic [6:0] c;
    unique case (idx)
      4'd0:    c = CHAR_COLON;
      4'd8:    c = 7'h31;
      4'd9:    c = 7'h46;
      4'd10:   c = 7'h46;
      4'd11:   c = CHAR_NEWLINE;
      default: c = CHAR_ZERO;
    endcase
    return c;
  endfunction

endpackage

// ----- src/hex_record_encoder.sv -----
// Channel   Handshake               Payload
// --------  ----------------------  ------------------------------------
// cfg       cfg_valid / cfg_ready   cfg_index (0 origin, 1 length), cfg_data
// byte in   byte_valid / byte_ready data_byte
// char out  char_valid / char_ready out_char, status, last_in_run
//
// Every result is one character; while a request waits and the output is not stalled,
// the sequencer sends one a cycle. A byte gives 2 characters, 11 if it opens a record,
// 3 more if it closes one and 12 more for the end record; a 16-byte record averages 2.75 a byte.
// A byte is classified as it is accepted and waits in a two-entry request queue.
// Reset is synchronous and clears the registers, the counters and the queue.
// An output stall holds the character register and, once the queue fills, drops byte_ready.
module hex_record_encoder (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             byte_valid,
  output logic                             byte_ready,
  input  logic [7:0]                       data_byte,
  output logic                             char_valid,
  input  logic                             char_ready,
  output logic [6:0]                       out_char,
  output logic [1:0]                       status,
  output logic                             last_in_run
);

  // Requests from the classifier to the sequencer.
  hre_pkg::cmd_t push_cmd, head;
  logic          push, pop, full, empty;

  // The front end holds the registers and the image position, checks each byte
  // against the image bounds, and works out the record framing and checksum.
  hre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .queue_full (full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  hre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // The back end walks the character positions of the request at the head of
  // the queue, skipping the parts that are not needed, and retires the request
  // with its last character.
  hre_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .out_char    (out_char),
    .status      (status),
    .last_in_run (last_in_run)
  );

endmodule

// ----- src/hre_front.sv -----
module hre_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hre_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [hre_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               byte_valid,
  output logic                               byte_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               queue_full,
  output logic                               push,
  output hre_pkg::cmd_t                      push_cmd
);

  logic [hre_pkg::ADDR_W-1:0] load_origin;
  logic [hre_pkg::LEN_W-1:0]  image_length;
  logic [hre_pkg::LEN_W-1:0]  byte_index;
  logic [hre_pkg::LEN_W-1:0]  rec_start;
  logic [hre_pkg::POS_W-1:0]  rec_pos;
  logic [7:0]                 running_sum;

  logic                       is_empty, is_overflow, is_past, is_err;
  logic [hre_pkg::LEN_W:0]    end_addr;
  logic [hre_pkg::LEN_W-1:0]  remain;
  logic [7:0]                 rec_count;
  logic                       last_image, last_record;
  logic [15:0]                rec_addr;
  logic [7:0]                 sum_base, sum_new;
  hre_pkg::status_t           err_code;

  assign cfg_ready = 1'b1;
  assign byte_ready = !queue_full;
  assign push = byte_valid && byte_ready;

  always_comb begin
    end_addr = {2'b00, load_origin} + {1'b0, image_length};
    is_empty = (image_length == '0);
    is_overflow = (end_addr > hre_pkg::ADDR_SPACE);
    is_past = (byte_index >= image_length);
    is_err = is_empty || is_overflow || is_past;
    priority if (is_empty) begin
      err_code = hre_pkg::ST_EMPTY;
    end else if (is_overflow) begin
      err_code = hre_pkg::ST_OVERFLOW;
    end else if (is_past) begin
      err_code = hre_pkg::ST_PAST_END;
    end else begin
      err_code = hre_pkg::ST_OK;
    end

    remain = image_length - rec_start;
    if (remain < hre_pkg::LEN_W'(hre_pkg::RECORD_BYTES)) begin
      rec_count = remain[7:0];
    end else begin
      rec_count = 8'(hre_pkg::RECORD_BYTES);
    end
    last_image = (byte_index + 1'b1) == image_length;
    last_record = ({{(8-hre_pkg::POS_W){1'b0}}, rec_pos} + 8'd1 == rec_count) || last_image;
    rec_addr = load_origin + rec_start[15:0];

    sum_base = (rec_pos == '0) ? (rec_count + rec_addr[15:8] + rec_addr[7:0]) : running_sum;
    sum_new = sum_base + data_byte;

    push_cmd.status = err_code;
    push_cmd.header = !is_err && (rec_pos == '0);
    push_cmd.checksum = !is_err && last_record;
    push_cmd.end_record = !is_err && last_image;
    push_cmd.count = rec_count;
    push_cmd.addr = rec_addr;
    push_cmd.data = data_byte;
    push_cmd.cks = 8'd0 - sum_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_origin <= '0;
      image_length <= '0;
      byte_index <= '0;
      rec_start <= '0;
      rec_pos <= '0;
      running_sum <= '0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == hre_pkg::REG_LOAD_ORIGIN) begin
          load_origin <= cfg_data[hre_pkg::ADDR_W-1:0];
        end else if (cfg_index == hre_pkg::REG_IMAGE_LENGTH) begin
          image_length <= cfg_data[hre_pkg::LEN_W-1:0];
        end
      end
      if (push && !is_err) begin
        byte_index <= byte_index + 1'b1;
        running_sum <= last_record ? 8'd0 : sum_new;
        if (rec_pos == hre_pkg::POS_W'(hre_pkg::RECORD_BYTES - 1)) begin
          rec_pos <= '0;
          rec_start <= rec_start + hre_pkg::LEN_W'(hre_pkg::RECORD_BYTES);
        end else begin
          rec_pos <= rec_pos + 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/hre_queue.sv -----
module hre_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hre_pkg::cmd_t  push_cmd,
  output logic           full,
  input  logic           pop,
  output hre_pkg::cmd_t  head,
  output logic           empty
);

  hre_pkg::cmd_t                entries [hre_pkg::QUEUE_DEPTH];
  logic [hre_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [hre_pkg::QUEUE_AW:0]   fill;

  assign full = (fill == (hre_pkg::QUEUE_AW+1)'(hre_pkg::QUEUE_DEPTH));
  assign empty = (fill == '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- src/hre_back.sv -----
module hre_back (
  input  logic           clk,
  input  logic           rst,
  input  hre_pkg::cmd_t  head,
  input  logic           empty,
  output logic           pop,
  output logic           char_valid,
  input  logic           char_ready,
  output logic [6:0]     out_char,
  output logic [1:0]     status,
  output logic           last_in_run
);

  hre_pkg::step_t step, cur_step, step_next;
  logic           fresh;
  logic           done;
  logic           advance;
  logic [6:0]     ch;
  logic [3:0]     end_idx;

  assign advance = !empty && (!char_valid || char_ready);
  assign pop = advance && done;
  assign end_idx = 4'(cur_step - hre_pkg::STEP_END_FIRST);

  always_comb begin
    if (fresh) begin
      cur_step = head.header ? hre_pkg::STEP_COLON : hre_pkg::STEP_DATA_HI;
    end else begin
      cur_step = step;
    end

    done = 1'b0;
    step_next = cur_step + 1'b1;
    if (head.status != hre_pkg::ST_OK) begin
      done = 1'b1;
    end else if (cur_step == hre_pkg::STEP_DATA_LO) begin
      if (head.checksum) begin
        step_next = hre_pkg::STEP_CKS_HI;
      end else if (head.end_record) begin
        step_next = hre_pkg::STEP_END_FIRST;
      end else begin
        done = 1'b1;
      end
    end else if (cur_step == hre_pkg::STEP_NEWLINE) begin
      done = !head.end_record;
    end else if (cur_step == hre_pkg::STEP_END_LAST) begin
      done = 1'b1;
    end

    if (head.status != hre_pkg::ST_OK) begin
      ch = hre_pkg::CHAR_NONE;
    end else if (cur_step >= hre_pkg::STEP_END_FIRST) begin
      ch = hre_pkg::end_char(end_idx);
    end else begin
      unique case (cur_step)
        hre_pkg::STEP_COLON:    ch = hre_pkg::CHAR_COLON;
        hre_pkg::STEP_COUNT_HI: ch = hre_pkg::hex_char(head.count[7:4]);
        hre_pkg::STEP_COUNT_LO: ch = hre_pkg::hex_char(head.count[3:0]);
        hre_pkg::STEP_ADDRH_HI: ch = hre_pkg::hex_char(head.addr[15:12]);
        hre_pkg::STEP_ADDRH_LO: ch = hre_pkg::hex_char(head.addr[11:8]);
        hre_pkg::STEP_ADDRL_HI: ch = hre_pkg::hex_char(head.addr[7:4]);
        hre_pkg::STEP_ADDRL_LO: ch = hre_pkg::hex_char(head.addr[3:0]);
        hre_pkg::STEP_DATA_HI:  ch = hre_pkg::hex_char(head.data[7:4]);
        hre_pkg::STEP_DATA_LO:  ch = hre_pkg::hex_char(head.data[3:0]);
        hre_pkg::STEP_CKS_HI:   ch = hre_pkg::hex_char(head.cks[7:4]);
        hre_pkg::STEP_CKS_LO:   ch = hre_pkg::hex_char(head.cks[3:0]);
        hre_pkg::STEP_NEWLINE:  ch = hre_pkg::CHAR_NEWLINE;
        default:                ch = hre_pkg::CHAR_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      fresh <= 1'b1;
      step <= hre_pkg::STEP_COLON;
    end else begin
      if (advance) begin
        char_valid <= 1'b1;
        fresh <= done;
        step <= step_next;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_char <= ch;
      status <= head.status;
      last_in_run <= done;
    end
  end

endmodule

// ----- src/hre_checker.sv -----
module hre_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             char_valid,
  input logic                             char_ready,
  input logic [6:0]                       out_char,
  input logic [1:0]                       status,
  input logic                             last_in_run
);

  // An error result is a single zero character that closes its run.
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    (char_valid && status != hre_pkg::ST_OK) |-> (out_char == '0 && last_in_run))
    else $error("error result is not a lone zero character");

  // Text results always carry a printable character or a newline.
  a_ok_char: assert property (@(posedge clk) disable iff (rst)
    (char_valid && status == hre_pkg::ST_OK) |-> (out_char != '0))
    else $error("text result carries a zero character");

  // A newline that does not close its run is the record end before an end record.
  a_colon_after_nl: assert property (@(posedge clk) disable iff (rst)
    (char_valid && char_ready && out_char == hre_pkg::CHAR_NEWLINE && !last_in_run)
      |=> (char_valid && out_char == hre_pkg::CHAR_COLON))
    else $error("end record does not follow the record newline");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !char_ready) |=>
      (char_valid && $stable(out_char) && $stable(status) && $stable(last_in_run)))
    else $error("stalled result changed");

endmodule

bind hex_record_encoder hre_checker u_hre_checker (.*);

// ----- tb/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes that the block does not decode; writes to them must be ignored.
  localparam logic [hre_pkg::CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [hre_pkg::CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int RANDOM_BYTES = 197;
  localparam int MAX_GAP = 19;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS = 8_000_000;

  localparam string HEX_DIGITS = "0123456789ABCDEF";
  localparam string EOF_TEXT = ":00000001FF";

  // One character of expected hex text together with its side fields.
  typedef struct packed {
    logic [6:0]       ch;
    hre_pkg::status_t st;
    logic             last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [hre_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hre_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            byte_valid = 1'b0;
  logic                            byte_ready;
  logic [7:0]                      data_byte = '0;
  logic                            char_valid;
  logic                            char_ready = 1'b0;
  logic [6:0]                      out_char;
  logic [1:0]                      status;
  logic                            last_in_run;

  hex_record_encoder dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .out_char   (out_char),
    .status     (status),
    .last_in_run(last_in_run)
  );

  always #5 clk = ~clk;

  // Image bytes waiting to be offered, and the hex text that the bytes
  // accepted so far must still produce, oldest character first.
  logic [7:0] pending_bytes[$];
  text_char_t expected_text[$];
  logic [6:0] line_chars[$];

  // Our own copy of the encoder's registers and running state.
  logic [15:0] origin_reg = '0;
  logic [16:0] length_reg = '0;
  logic [16:0] bytes_taken = '0;
  logic [7:0]  record_sum = '0;

  int failures = 0;
  int encoded_bytes = 0;
  int rejected_bytes = 0;
  int chars_checked = 0;
  int long_holds = 0;
  int settings_used = 0;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    return 7'(HEX_DIGITS[nib]);
  endfunction

  function automatic void add_hex(input logic [7:0] value);
    line_chars.push_back(hex_digit(value[7:4]));
    line_chars.push_back(hex_digit(value[3:0]));
  endfunction

  // Works out the text that one accepted image byte produces and queues it.
  // A rejected byte gives a single status character and leaves the state alone.
  function automatic void encode_byte(input logic [7:0] data);
    logic [17:0]      span;
    logic [16:0]      pos, rec_start, remain, rec_count;
    logic [15:0]      addr;
    logic             last_rec, last_img;
    hre_pkg::status_t verdict;
    text_char_t       item;
    span = 18'(origin_reg) + 18'(length_reg);
    verdict = hre_pkg::ST_OK;
    if (length_reg == 17'd0) begin
      verdict = hre_pkg::ST_EMPTY;
    end else if (span > 18'h10000) begin
      verdict = hre_pkg::ST_OVERFLOW;
    end else if (bytes_taken >= length_reg) begin
      verdict = hre_pkg::ST_PAST_END;
    end
    if (verdict != hre_pkg::ST_OK) begin
      item.ch = hre_pkg::CHAR_NONE;
      item.st = verdict;
      item.last = 1'b1;
      expected_text.push_back(item);
      rejected_bytes++;
      return;
    end

    line_chars.delete();
    pos = bytes_taken % hre_pkg::RECORD_BYTES;
    rec_start = bytes_taken - pos;
    remain = length_reg - rec_start;
    rec_count = (remain < hre_pkg::RECORD_BYTES) ? remain : 17'(hre_pkg::RECORD_BYTES);
    last_img = (bytes_taken + 17'd1 == length_reg);
    last_rec = (pos + 17'd1 == rec_count) || last_img;

    // A byte at a record boundary opens the record: colon, count, address, type.
    if (pos == 17'd0) begin
      addr = 16'(17'(origin_reg) + rec_start);
      line_chars.push_back(hre_pkg::CHAR_COLON);
      add_hex(8'(rec_count));
      add_hex(addr[15:8]);
      add_hex(addr[7:0]);
      add_hex(8'h00);
      record_sum = 8'(rec_count) + addr[15:8] + addr[7:0];
    end

    add_hex(data);
    record_sum = record_sum + data;

    if (last_rec) begin
      add_hex(8'h00 - record_sum);
      line_chars.push_back(hre_pkg::CHAR_NEWLINE);
      record_sum = '0;
    end

    if (last_img) begin
      for (int i = 0; i < EOF_TEXT.len(); i++) begin
        line_chars.push_back(7'(EOF_TEXT[i]));
      end
      line_chars.push_back(hre_pkg::CHAR_NEWLINE);
    end

    bytes_taken = bytes_taken + 17'd1;
    encoded_bytes++;
    for (int i = 0; i < line_chars.size(); i++) begin
      item.ch = line_chars[i];
      item.st = hre_pkg::ST_OK;
      item.last = (i == line_chars.size() - 1);
      expected_text.push_back(item);
    end
  endfunction

  // Sender: offers the queued image bytes one request at a time. After each
  // accepted request it draws a gap, except in burst stretches where it
  // offers back to back. The encoding is predicted at the accepting edge.
  logic send_burst = 1'b0;
  int   send_wait = 0;

  always @(posedge clk) begin : byte_sender
    int gap;
    if (rst) begin
      byte_valid <= 1'b0;
      send_wait <= 0;
    end else if (!(byte_valid && !byte_ready)) begin
      if (byte_valid) begin
        encode_byte(data_byte);
        if ($urandom_range(0, 24) == 0) begin
          send_burst = !send_burst;
        end
        gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        gap = send_wait;
      end
      if (gap == 0 && pending_bytes.size() != 0) begin
        byte_valid <= 1'b1;
        data_byte <= pending_bytes.pop_front();
        send_wait <= 0;
      end else begin
        byte_valid <= 1'b0;
        send_wait <= (gap == 0) ? 0 : gap - 1;
      end
    end
  end

  // Receiver: checks every accepted character against the oldest expectation
  // and then stalls for a random number of cycles. When the sender has a deep
  // backlog it sometimes holds off for a long stretch, so that the block's
  // request queue fills and byte_ready has to drop.
  logic recv_burst = 1'b0;
  int   recv_wait = 0;
  int   next_hold_at = 100;

  always @(posedge clk) begin : char_receiver
    int stall;
    text_char_t want;
    if (rst) begin
      char_ready <= 1'b0;
      recv_wait <= 0;
    end else begin
      stall = 0;
      if (char_valid && char_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character: out_char %h status %0d last_in_run %b",
                 out_char, status, last_in_run);
          failures++;
        end else begin
          want = expected_text.pop_front();
          if (out_char !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, out_char);
            failures++;
          end
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            failures++;
          end
          if (last_in_run !== want.last) begin
            $error("last_in_run: expected %b, got %b", want.last, last_in_run);
            failures++;
          end
        end
        chars_checked++;
        if ($urandom_range(0, 29) == 0) begin
          recv_burst = !recv_burst;
        end
        if (long_holds < 3 && chars_checked >= next_hold_at && pending_bytes.size() >= 12) begin
          stall = HOLD_CYCLES;
          long_holds++;
          next_hold_at = chars_checked + 500;
        end else begin
          stall = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
        end
      end else if (!char_ready) begin
        stall = recv_wait;
      end
      if (stall == 0) begin
        char_ready <= 1'b1;
      end else begin
        char_ready <= 1'b0;
        recv_wait <= stall - 1;
      end
    end
  end

  // The block counts as idle once every queued byte has been accepted and
  // every character it must produce has come out.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || byte_valid || expected_text.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [hre_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [hre_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    if (idx == hre_pkg::REG_LOAD_ORIGIN) begin
      origin_reg = value[15:0];
    end else if (idx == hre_pkg::REG_IMAGE_LENGTH) begin
      length_reg = value;
    end
  endtask

  // Writes both registers back to back, optionally with writes to the
  // undecoded indexes mixed in, and only drops the request at the end.
  task automatic configure(input logic [hre_pkg::CFG_DATA_W-1:0] origin,
                           input logic [hre_pkg::CFG_DATA_W-1:0] length,
                           input bit with_spare);
    if (with_spare) begin
      write_reg(REG_SPARE_2, hre_pkg::CFG_DATA_W'($urandom));
    end
    write_reg(hre_pkg::REG_LOAD_ORIGIN, origin);
    if (with_spare) begin
      write_reg(REG_SPARE_3, hre_pkg::CFG_DATA_W'($urandom));
    end
    write_reg(hre_pkg::REG_IMAGE_LENGTH, length);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int cur, k, nsend, random_items;
    logic [16:0] len, top;
    logic [15:0] org;
    random_items = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Registers still hold their reset values, so the image is empty.
    pending_bytes.push_back(8'h00);
    wait_idle();

    // Origin written with its spare top bit set; 0xFFFF plus two bytes runs
    // past the end of the address space.
    configure(17'h1FFFF, 17'd2, 1'b0);
    pending_bytes.push_back(8'hFF);
    wait_idle();

    // A one-byte image at the very last address, then a byte past its end.
    configure(17'h0FFFF, 17'd1, 1'b1);
    pending_bytes.push_back(8'hA5);
    pending_bytes.push_back(8'h5A);
    wait_idle();

    // Largest legal image. It resumes in the middle of the first record,
    // closes it, and opens the next one with a full header.
    configure(17'd0, 17'h10000, 1'b0);
    for (int i = 0; i < 17; i++) begin
      pending_bytes.push_back(8'(i * 17));
    end
    wait_idle();

    // Overflow is reported ahead of a byte past the end, and then an empty image
    // at origin 0xFFFF is reported as empty.
    configure(17'h0FFFF, 17'(bytes_taken), 1'b0);
    pending_bytes.push_back(8'h3C);
    wait_idle();
    configure(17'h0FFFF, 17'd0, 1'b0);
    pending_bytes.push_back(8'hC3);
    wait_idle();

    // Random part: mostly complete images that start wherever the byte count
    // stands, some cut short so the next setting lands mid-image, some with a
    // trailing extra byte, and a few settings that are rejected outright.
    while (random_items < RANDOM_BYTES) begin
      cur = int'(bytes_taken);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            len = 17'd0;
            org = 16'($urandom);
          end
          1: begin
            len = 17'(cur + $urandom_range(1, 40));
            org = 16'($urandom_range(65537 - int'(len), 65535));
          end
          default: begin
            len = 17'($urandom_range(1, cur));
            org = 16'($urandom_range(0, 65536 - int'(len)));
          end
        endcase
        nsend = $urandom_range(1, 3);
      end else begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 32);
        len = 17'(cur + k);
        top = 17'h10000 - len;
        case ($urandom_range(0, 3))
          0:       org = 16'(top);
          1:       org = 16'd0;
          default: org = 16'($urandom_range(0, int'(top)));
        endcase
        nsend = k;
        if (k > 1 && $urandom_range(0, 4) == 0) begin
          nsend = $urandom_range(1, k - 1);
        end else if ($urandom_range(0, 2) == 0) begin
          nsend = k + 1;
        end
      end
      // The last image is cut to the byte budget.
      if (nsend > RANDOM_BYTES - random_items) begin
        nsend = RANDOM_BYTES - random_items;
      end
      configure(17'(org), len, $urandom_range(0, 5) == 0);
      repeat (nsend) begin
        pending_bytes.push_back(8'($urandom));
        random_items++;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes over %0d register settings: %0d encoded, %0d rejected.",
             encoded_bytes + rejected_bytes, settings_used, encoded_bytes, rejected_bytes);
    $display("Checked %0d characters with %0d long output hold-offs.",
             chars_checked, long_holds);
    if (failures == 0 && expected_text.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- hex_record_encoder.f -----
src/hre_pkg.sv
src/hre_front.sv
src/hre_queue.sv
src/hre_back.sv
src/hex_record_encoder.sv
src/hre_checker.sv
tb/tb.sv
